// ===== hdl/mprs_pkg.sv =====
// Shared types and constants for the matrix power block.
`timescale 1ns / 1ps
package mprs_pkg;

    localparam int DATA_W     = 32;
    localparam int MAX_SIZE   = 8;
    localparam int IDX_W      = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int SIZE_W     = 4;
    localparam int ADDR_W     = 2 * IDX_W;
    localparam int CNT_W      = ADDR_W + 1;
    localparam int FRAC_BITS  = 16;
    localparam int SUM_W      = 2 * DATA_W + IDX_W + 1;
    localparam int EXP_W      = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_DATA_W = 40;
    localparam int STATE_W    = 3;

    localparam logic [CFG_IDX_W-1:0] REG_EXPONENT    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MATRIX_SIZE = CFG_IDX_W'(1);

    typedef logic signed [DATA_W-1:0]   data_t;
    typedef logic signed [2*DATA_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]    sum_t;
    typedef logic [IDX_W-1:0]           idx_t;
    typedef logic [SIZE_W-1:0]          dim_t;
    typedef logic [CNT_W-1:0]           cnt_t;

    localparam data_t ONE    = data_t'(1) <<< FRAC_BITS;
    localparam sum_t  RND    = (sum_t'(1) <<< FRAC_BITS) >>> 1;
    localparam sum_t  SAT_HI = (sum_t'(1) <<< (DATA_W - 1)) - sum_t'(1);
    localparam sum_t  SAT_LO = -(sum_t'(1) <<< (DATA_W - 1));

    typedef struct packed {
        logic valid;
        idx_t row;
        idx_t col;
        sum_t sum;
    } token_t;

    typedef struct packed {
        logic  base_en;
        logic  acc_en;
        idx_t  row;
        idx_t  col;
        data_t base_val;
        data_t acc_val;
    } wr_t;

    typedef struct packed {
        logic  valid;
        idx_t  row;
        idx_t  col;
        data_t value;
        logic  sat;
    } res_t;

endpackage

// ===== hdl/mprs_cell.sv =====
// One multiply-accumulate cell of the dot-product chain, holding one column and row.
`timescale 1ns / 1ps
module mprs_cell
(
    input  logic            clk,
    input  logic            rst_n,
    input  mprs_pkg::idx_t  cell_idx,
    input  mprs_pkg::dim_t  size,
    input  logic            op_sq,
    input  mprs_pkg::wr_t   wr,
    input  mprs_pkg::token_t tok_in,
    output mprs_pkg::token_t tok_out,
    input  mprs_pkg::idx_t  rd_row,
    output mprs_pkg::data_t rd_acc
);

    mprs_pkg::data_t  acol [mprs_pkg::MAX_SIZE];
    mprs_pkg::data_t  bcol [mprs_pkg::MAX_SIZE];
    mprs_pkg::data_t  brow [mprs_pkg::MAX_SIZE];

    mprs_pkg::token_t t1_reg;
    mprs_pkg::token_t out_reg;
    mprs_pkg::prod_t  prod_reg;
    mprs_pkg::prod_t  prod_next;
    mprs_pkg::data_t  a_op;
    mprs_pkg::data_t  b_op;
    logic             active;

    always_comb
    begin
        a_op      = op_sq ? bcol[tok_in.row] : acol[tok_in.row];
        b_op      = brow[tok_in.col];
        active    = mprs_pkg::SIZE_W'(cell_idx) < size;
        prod_next = active ? (mprs_pkg::prod_t'(a_op) * mprs_pkg::prod_t'(b_op))
                           : mprs_pkg::prod_t'(0);
    end

    always_ff @(posedge clk)
    begin
        if (wr.base_en)
        begin
            if (wr.col == cell_idx)
            begin
                bcol[wr.row] <= wr.base_val;
            end
            if (wr.row == cell_idx)
            begin
                brow[wr.col] <= wr.base_val;
            end
        end
        if (wr.acc_en && (wr.col == cell_idx))
        begin
            acol[wr.row] <= wr.acc_val;
        end
        prod_reg <= prod_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_reg  <= '0;
            out_reg <= '0;
        end
        else
        begin
            t1_reg  <= tok_in;
            out_reg <= '{valid: t1_reg.valid,
                         row:   t1_reg.row,
                         col:   t1_reg.col,
                         sum:   t1_reg.sum + mprs_pkg::sum_t'(prod_reg)};
        end
    end

    assign tok_out = out_reg;
    assign rd_acc  = acol[rd_row];

endmodule

// ===== hdl/mprs_round.sv =====
// Rounding and saturation of a finished dot product to the element format.
`timescale 1ns / 1ps
module mprs_round
(
    input  logic             clk,
    input  logic             rst_n,
    input  mprs_pkg::token_t tok,
    output mprs_pkg::res_t   res
);

    mprs_pkg::sum_t rnd;
    mprs_pkg::sum_t shifted;
    mprs_pkg::res_t res_reg;
    mprs_pkg::res_t res_next;

    always_comb
    begin
        rnd            = tok.sum + mprs_pkg::RND;
        shifted        = rnd >>> mprs_pkg::FRAC_BITS;
        res_next.valid = tok.valid;
        res_next.row   = tok.row;
        res_next.col   = tok.col;
        if (shifted > mprs_pkg::SAT_HI)
        begin
            res_next.value = mprs_pkg::data_t'(mprs_pkg::SAT_HI);
            res_next.sat   = 1'b1;
        end
        else if (shifted < mprs_pkg::SAT_LO)
        begin
            res_next.value = mprs_pkg::data_t'(mprs_pkg::SAT_LO);
            res_next.sat   = 1'b1;
        end
        else
        begin
            res_next.value = shifted[mprs_pkg::DATA_W-1:0];
            res_next.sat   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= '0;
        end
        else
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// ===== hdl/matrix_power_repeated_squaring.sv =====
// Top level: element load, exponent walk, cell chain and result stream.
//
//  channel   | dir | handshake             | payload
//  s_axis    | in  | s_axis_tvalid/tready  | tdata element, tlast last element
//  m_axis    | out | m_axis_tvalid/tready  | tdata value,row,col; tuser sat; tlast
//  cfg       | in  | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
//  Load: one element per cycle while idle. After the last element, a set-up sweep
//  over n*n positions; then per product n*n injections through the cell and rounding
//  registers and an n*n copy sweep through the scratch memory, plus a decide step.
//  Results leave at one per cycle while m_axis_tready holds.
//  Reset clears all control state; no memory clearing pass.
//  The input stalls from the last element until the final result is loaded.
`timescale 1ns / 1ps
module matrix_power_repeated_squaring
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [mprs_pkg::DATA_W-1:0]       s_axis_tdata,   // element_value
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [mprs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // result_value, result_row, result_col
    output logic                              m_axis_tuser,   // saturated
    output logic                              m_axis_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mprs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mprs_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam logic [mprs_pkg::STATE_W-1:0] ST_IDLE   = 3'd0;
    localparam logic [mprs_pkg::STATE_W-1:0] ST_INIT   = 3'd1;
    localparam logic [mprs_pkg::STATE_W-1:0] ST_DECIDE = 3'd2;
    localparam logic [mprs_pkg::STATE_W-1:0] ST_MUL    = 3'd3;
    localparam logic [mprs_pkg::STATE_W-1:0] ST_COPY   = 3'd4;
    localparam logic [mprs_pkg::STATE_W-1:0] ST_OUT    = 3'd5;

    logic [mprs_pkg::STATE_W-1:0] state_reg;
    logic [mprs_pkg::EXP_W-1:0]   exponent_reg;
    mprs_pkg::dim_t               size_cfg_reg;
    mprs_pkg::dim_t               n_reg;
    mprs_pkg::cnt_t               load_cnt_reg;
    mprs_pkg::cnt_t               lc_reg;
    mprs_pkg::cnt_t               lin_reg;
    mprs_pkg::cnt_t               res_cnt_reg;
    logic [mprs_pkg::EXP_W-1:0]   exp_reg;
    logic                         acc_done_reg;
    logic                         op_sq_reg;
    logic                         inj_done_reg;
    mprs_pkg::idx_t               row_reg;
    mprs_pkg::idx_t               col_reg;
    logic                         sat_reg;
    logic                         bc_init_reg;
    logic                         bc_base_reg;
    logic                         bc_acc_reg;
    logic                         bc_ld_reg;
    mprs_pkg::idx_t               bc_row_reg;
    mprs_pkg::idx_t               bc_col_reg;

    logic                         out_valid_reg;
    mprs_pkg::data_t              out_value_reg;
    mprs_pkg::idx_t               out_row_reg;
    mprs_pkg::idx_t               out_col_reg;
    logic                         out_sat_reg;
    logic                         out_last_reg;

    mprs_pkg::data_t              mem [2**mprs_pkg::ADDR_W];
    mprs_pkg::data_t              rdata_reg;
    logic                         mem_wen;
    logic [mprs_pkg::ADDR_W-1:0]  mem_waddr;
    mprs_pkg::data_t              mem_wdata;
    logic [mprs_pkg::ADDR_W-1:0]  mem_raddr;

    mprs_pkg::dim_t               n_cur;
    mprs_pkg::cnt_t               cells_cur;
    mprs_pkg::cnt_t               cells_run;
    mprs_pkg::idx_t               n_last;
    logic                         last_pos;
    logic                         in_fire;
    logic                         out_load;

    mprs_pkg::token_t             tok [mprs_pkg::MAX_SIZE+1];
    mprs_pkg::data_t              cell_acc [mprs_pkg::MAX_SIZE];
    mprs_pkg::wr_t                wr;
    mprs_pkg::res_t               res;

    always_comb
    begin
        if (size_cfg_reg == '0)
        begin
            n_cur = mprs_pkg::dim_t'(1);
        end
        else if (size_cfg_reg > mprs_pkg::dim_t'(mprs_pkg::MAX_SIZE))
        begin
            n_cur = mprs_pkg::dim_t'(mprs_pkg::MAX_SIZE);
        end
        else
        begin
            n_cur = size_cfg_reg;
        end
        cells_cur = mprs_pkg::cnt_t'(n_cur) * mprs_pkg::cnt_t'(n_cur);
        cells_run = mprs_pkg::cnt_t'(n_reg) * mprs_pkg::cnt_t'(n_reg);
        n_last    = mprs_pkg::IDX_W'(n_reg - mprs_pkg::dim_t'(1));
        last_pos  = (row_reg == n_last) && (col_reg == n_last);
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_load      = (state_reg == ST_OUT) && (!out_valid_reg || m_axis_tready);
    assign cfg_ready     = 1'b1;

    always_comb
    begin
        mem_wen   = 1'b0;
        mem_waddr = load_cnt_reg[mprs_pkg::ADDR_W-1:0];
        mem_wdata = mprs_pkg::data_t'(s_axis_tdata);
        if (in_fire && (load_cnt_reg < cells_cur))
        begin
            mem_wen = 1'b1;
        end
        else if ((state_reg == ST_MUL) && res.valid)
        begin
            mem_wen   = 1'b1;
            mem_waddr = {res.row, res.col};
            mem_wdata = res.value;
        end
        mem_raddr = (state_reg == ST_INIT) ? lin_reg[mprs_pkg::ADDR_W-1:0]
                                           : {row_reg, col_reg};
    end

    always_ff @(posedge clk)
    begin
        if (mem_wen)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        wr.base_en  = bc_init_reg || bc_base_reg;
        wr.acc_en   = bc_init_reg || bc_acc_reg;
        wr.row      = bc_row_reg;
        wr.col      = bc_col_reg;
        wr.base_val = (bc_init_reg && !bc_ld_reg) ? mprs_pkg::data_t'(0) : rdata_reg;
        if (bc_init_reg)
        begin
            wr.acc_val = (bc_row_reg == bc_col_reg) ? mprs_pkg::ONE : mprs_pkg::data_t'(0);
        end
        else
        begin
            wr.acc_val = rdata_reg;
        end
        tok[0].valid = (state_reg == ST_MUL) && !inj_done_reg;
        tok[0].row   = row_reg;
        tok[0].col   = col_reg;
        tok[0].sum   = '0;
    end

    for (genvar gi = 0; gi < mprs_pkg::MAX_SIZE; gi++)
    begin : g_cell
        mprs_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (mprs_pkg::IDX_W'(gi)),
            .size     (n_reg),
            .op_sq    (op_sq_reg),
            .wr       (wr),
            .tok_in   (tok[gi]),
            .tok_out  (tok[gi+1]),
            .rd_row   (row_reg),
            .rd_acc   (cell_acc[gi])
        );
    end

    mprs_round u_round
    (
        .clk   (clk),
        .rst_n (rst_n),
        .tok   (tok[mprs_pkg::MAX_SIZE]),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exponent_reg <= mprs_pkg::EXP_W'(1);
            size_cfg_reg <= mprs_pkg::dim_t'(mprs_pkg::MAX_SIZE);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                mprs_pkg::REG_EXPONENT:    exponent_reg <= cfg_data;
                mprs_pkg::REG_MATRIX_SIZE: size_cfg_reg <= cfg_data[mprs_pkg::SIZE_W-1:0];
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            n_reg         <= mprs_pkg::dim_t'(1);
            load_cnt_reg  <= '0;
            lc_reg        <= '0;
            lin_reg       <= '0;
            res_cnt_reg   <= '0;
            exp_reg       <= '0;
            acc_done_reg  <= 1'b0;
            op_sq_reg     <= 1'b0;
            inj_done_reg  <= 1'b0;
            row_reg       <= '0;
            col_reg       <= '0;
            sat_reg       <= 1'b0;
            bc_init_reg   <= 1'b0;
            bc_base_reg   <= 1'b0;
            bc_acc_reg    <= 1'b0;
            bc_ld_reg     <= 1'b0;
            bc_row_reg    <= '0;
            bc_col_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            out_sat_reg   <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            bc_init_reg <= (state_reg == ST_INIT);
            bc_base_reg <= (state_reg == ST_COPY) && op_sq_reg;
            bc_acc_reg  <= (state_reg == ST_COPY) && !op_sq_reg;
            bc_ld_reg   <= lin_reg < lc_reg;
            bc_row_reg  <= row_reg;
            bc_col_reg  <= col_reg;

            if (m_axis_tready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (s_axis_tlast)
                        begin
                            lc_reg       <= (load_cnt_reg < cells_cur)
                                            ? load_cnt_reg + mprs_pkg::cnt_t'(1)
                                            : load_cnt_reg;
                            load_cnt_reg <= '0;
                            n_reg        <= n_cur;
                            exp_reg      <= exponent_reg;
                            sat_reg      <= 1'b0;
                            acc_done_reg <= 1'b0;
                            lin_reg      <= '0;
                            row_reg      <= '0;
                            col_reg      <= '0;
                            state_reg    <= ST_INIT;
                        end
                        else if (load_cnt_reg < cells_cur)
                        begin
                            load_cnt_reg <= load_cnt_reg + mprs_pkg::cnt_t'(1);
                        end
                    end
                end
                ST_INIT, ST_COPY, ST_MUL:
                begin
                    if ((state_reg != ST_MUL) || !inj_done_reg)
                    begin
                        lin_reg <= lin_reg + mprs_pkg::cnt_t'(1);
                        if (last_pos)
                        begin
                            row_reg <= '0;
                            col_reg <= '0;
                            if (state_reg == ST_MUL)
                            begin
                                inj_done_reg <= 1'b1;
                            end
                            else
                            begin
                                state_reg <= ST_DECIDE;
                            end
                        end
                        else if (col_reg == n_last)
                        begin
                            col_reg <= '0;
                            row_reg <= row_reg + mprs_pkg::idx_t'(1);
                        end
                        else
                        begin
                            col_reg <= col_reg + mprs_pkg::idx_t'(1);
                        end
                    end
                    if ((state_reg == ST_MUL) && res.valid)
                    begin
                        res_cnt_reg <= res_cnt_reg + mprs_pkg::cnt_t'(1);
                        sat_reg     <= sat_reg || res.sat;
                        if (res_cnt_reg == cells_run - mprs_pkg::cnt_t'(1))
                        begin
                            row_reg   <= '0;
                            col_reg   <= '0;
                            state_reg <= ST_COPY;
                        end
                    end
                end
                ST_DECIDE:
                begin
                    row_reg      <= '0;
                    col_reg      <= '0;
                    inj_done_reg <= 1'b0;
                    res_cnt_reg  <= '0;
                    if (exp_reg == '0)
                    begin
                        state_reg <= ST_OUT;
                    end
                    else if (exp_reg[0] && !acc_done_reg)
                    begin
                        acc_done_reg <= 1'b1;
                        op_sq_reg    <= 1'b0;
                        state_reg    <= ST_MUL;
                    end
                    else
                    begin
                        exp_reg      <= exp_reg >> 1;
                        acc_done_reg <= 1'b0;
                        if ((exp_reg >> 1) != '0)
                        begin
                            op_sq_reg <= 1'b1;
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_OUT:
                begin
                    if (out_load)
                    begin
                        out_valid_reg <= 1'b1;
                        out_value_reg <= cell_acc[col_reg];
                        out_row_reg   <= row_reg;
                        out_col_reg   <= col_reg;
                        out_sat_reg   <= sat_reg;
                        out_last_reg  <= last_pos;
                        if (last_pos)
                        begin
                            row_reg   <= '0;
                            col_reg   <= '0;
                            state_reg <= ST_IDLE;
                        end
                        else if (col_reg == n_last)
                        begin
                            col_reg <= '0;
                            row_reg <= row_reg + mprs_pkg::idx_t'(1);
                        end
                        else
                        begin
                            col_reg <= col_reg + mprs_pkg::idx_t'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_col_reg, out_row_reg, out_value_reg};
    assign m_axis_tuser  = out_sat_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// ===== hdl/mprs_checker.sv =====
// Port-level checks for the matrix power block, bound to the top level.
`timescale 1ns / 1ps
module mprs_props
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [mprs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input logic                              m_axis_tuser,
    input logic                              m_axis_tlast
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item changed while stalled");

    a_last_diag: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[34:32] == m_axis_tdata[37:35])
        else $error("final item not on the diagonal");

    a_run_dense: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
        else $error("gap inside a result run");

    a_run_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> $stable(m_axis_tuser))
        else $error("saturation flag changed within a run");

endmodule

bind matrix_power_repeated_squaring mprs_props u_mprs_props
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
